### design/oets_pkg.sv
// Shared types and defaults for the odd-even transposition sorter.
// No dependencies; imported by the cell and the top level.
package oets_pkg;

   localparam int DEFAULT_MAX_ELEMENTS = 64;
   localparam int DEFAULT_DATA_WIDTH   = 32;

   // Operation applied by every cell of the chain in a given cycle.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_IN,
      CELL_SORT,
      CELL_SHIFT_OUT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        odd_phase;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_EMIT
   } sorter_state_type;

endpackage

### design/oets_cell.sv
// One storage cell of the sorting chain: holds one element and swaps with its right neighbor.
// Depends on oets_pkg for the cell control struct.
module oets_cell import oets_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH,
   parameter int CNT_W      = 7,
   parameter int CELL_INDEX = 0
) (
   input  logic                         clock,
   input  cell_ctrl_type                ctrl,
   input  logic [CNT_W-1:0]             count,
   input  logic signed [DATA_WIDTH-1:0] data_left,
   input  logic signed [DATA_WIDTH-1:0] data_right,
   input  logic                         swap_in,
   output logic signed [DATA_WIDTH-1:0] value,
   output logic                         swap_out
);

   localparam logic [CNT_W-1:0] PAIR_END = CNT_W'(CELL_INDEX + 1);
   localparam logic             IS_ODD   = 1'(CELL_INDEX % 2);

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;
   logic                         pair_active;

   // This cell leads a pair when its parity matches the phase and the partner holds data.
   assign pair_active = (IS_ODD == ctrl.odd_phase) && (PAIR_END < count);
   assign swap_out    = (ctrl.op == CELL_SORT) && pair_active && (value_ff > data_right);

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
            value_in = value_ff;
         end
         CELL_SHIFT_IN: begin
            value_in = data_left;
         end
         CELL_SORT: begin
            if (swap_out) begin
               value_in = data_right;
            end else if (swap_in) begin
               value_in = data_left;
            end
         end
         CELL_SHIFT_OUT: begin
            value_in = data_right;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### design/odd_even_transposition_sorter.sv
// Odd-even transposition sorter: a run of items is accepted, then sorted in alternating
// odd and even phases, one phase per stored element, then emitted as results; the first
// result is shown after the first emission cycle loads it into the output register, and
// busy stays high through the sort and the emission.
// The row of cells performs one compare-exchange per active adjacent pair in each phase.
// The receiver cannot stall; results come one per cycle without gaps.
// Reset (synchronous, active high) empties the store and clears the overflow flag.
module odd_even_transposition_sorter import oets_pkg::*; #(
   parameter int MAX_ELEMENTS = DEFAULT_MAX_ELEMENTS,
   parameter int DATA_WIDTH   = DEFAULT_DATA_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic                         req_last,
   output logic                         rsp_strobe,
   output logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                         rsp_last_out,
   output logic                         rsp_overflow
);

   // The element count must reach MAX_ELEMENTS itself.
   localparam int               CNT_W   = $clog2(MAX_ELEMENTS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

   sorter_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] phase_ff, phase_in;
   logic             odd_ff, odd_in;
   logic             ovf_ff, ovf_in;
   cell_ctrl_type    cell_ctrl;

   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic signed [DATA_WIDTH-1:0] cell_value [MAX_ELEMENTS];
   logic                         cell_swap  [MAX_ELEMENTS];

   // The chain: new items enter at cell 0 and push older ones right. Sorting leaves the
   // smallest element in cell 0, and emission shifts the row left one cell per cycle.
   for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] left_data;
      logic signed [DATA_WIDTH-1:0] right_data;
      logic                         left_swap;

      if (g == 0) begin : g_head
         assign left_data = req_value;
         assign left_swap = 1'b0;
      end else begin : g_body
         assign left_data = cell_value[g-1];
         assign left_swap = cell_swap[g-1];
      end

      if (g == MAX_ELEMENTS - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_next
         assign right_data = cell_value[g+1];
      end

      oets_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .CNT_W      (CNT_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count_ff),
         .data_left  (left_data),
         .data_right (right_data),
         .swap_in    (left_swap),
         .value      (cell_value[g]),
         .swap_out   (cell_swap[g])
      );
   end

   // Sequencer. In load, each accepted item is stored if there is room, otherwise the
   // run is marked as overflowed; the item carrying last starts the sort. Exactly n
   // alternating phases sort n elements, so no swap detection is needed. Emission
   // counts the element count down to zero, which also readies the store for the next run.
   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      phase_in         = phase_ff;
      odd_in           = odd_ff;
      ovf_in           = ovf_ff;
      cell_ctrl.op     = CELL_HOLD;
      cell_ctrl.odd_phase = odd_ff;
      rsp_strobe_in    = 1'b0;
      rsp_value_in     = cell_value[0];
      rsp_last_in      = (count_ff == ONE);
      rsp_ovf_in       = ovf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (start) begin
               if (count_ff < MAX_CNT) begin
                  cell_ctrl.op = CELL_SHIFT_IN;
                  count_in     = count_ff + ONE;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_SORT;
                  phase_in = '0;
               end
            end
         end
         ST_SORT: begin
            cell_ctrl.op = CELL_SORT;
            odd_in       = ~odd_ff;
            phase_in     = phase_ff + ONE;
            if (phase_ff == count_ff - ONE) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cell_ctrl.op  = CELL_SHIFT_OUT;
            rsp_strobe_in = 1'b1;
            count_in      = count_ff - ONE;
            if (count_ff == ONE) begin
               state_in = ST_LOAD;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         phase_ff      <= '0;
         odd_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         odd_ff        <= odd_in;
         ovf_ff        <= ovf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Result payload is registered alongside the strobe.
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign busy             = (state_ff != ST_LOAD);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_last_out     = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

`ifndef SYNTHESIS
   // The store never claims more elements than there are cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("element count beyond capacity");

   // The final result of a run is shown exactly when the block is ready again.
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_out) |-> !busy)
      else $error("final result while still busy");

   // No result appears while the chain is sorting.
   a_no_rsp_in_sort: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> !rsp_strobe)
      else $error("result strobe during sort");

   // Emission always ends with a marked final result.
   a_emit_ends_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && count_ff == ONE) |=> (rsp_strobe && rsp_last_out))
      else $error("run ended without final marker");
`endif

endmodule
